// File: src/bblur_pkg.sv
// Shared types, constants and a helper function for the 3x3 RGB box blur.
// Used by box_blur_3x3_rgb; depends on nothing else.
`default_nettype none

package bblur_pkg;

   // Field widths
   localparam int unsigned CH_W       = 8;
   localparam int unsigned PIX_W      = 3 * CH_W;
   localparam int unsigned FW_W       = 11;
   localparam int unsigned FH_W       = 13;
   localparam int unsigned ROW_W      = 13;
   localparam int unsigned COL_W      = 10;   // sum of three channel values
   localparam int unsigned TOT_W      = 12;   // sum of nine channel values
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 13;

   // Sizes and limits
   localparam int unsigned MAX_WIDTH_DEF = 1024;
   localparam int unsigned MAX_HEIGHT    = 4096;
   localparam int unsigned RSP_DEPTH     = 8;
   localparam int unsigned CH_MAX        = 255;

   // Reset values of the registers
   localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(480);

   // Divide by nine: multiply by 7282 / 2^16, exact for totals up to 2295
   localparam int unsigned RECIP9   = 7282;
   localparam int unsigned RECIP_W  = 13;
   localparam int unsigned RECIP_SH = 16;
   localparam int unsigned PROD_W   = TOT_W + RECIP_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_GRAY_MODE    = 2'd2
   } csr_index_type;

   typedef enum logic [0:0] {
      OP_PIXEL = 1'b0,
      OP_DRAIN = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type        opcode;
      logic [CH_W-1:0]   red_in;
      logic [CH_W-1:0]   green_in;
      logic [CH_W-1:0]   blue_in;
   } req_word_type;

   typedef struct packed {
      logic [CH_W-1:0]   red_out;
      logic [CH_W-1:0]   green_out;
      logic [CH_W-1:0]   blue_out;
      logic              frame_end;
   } rsp_word_type;

   // One line store entry: the pixel two rows up and one row up
   typedef struct packed {
      logic [PIX_W-1:0]  older;
      logic [PIX_W-1:0]  newer;
   } store_word_type;

   // Per-channel sum of one window column
   typedef struct packed {
      logic [COL_W-1:0]  r;
      logic [COL_W-1:0]  g;
      logic [COL_W-1:0]  b;
   } col_sum_type;

   // Mean of nine values from their total, clamped to the channel range
   function automatic logic [CH_W-1:0] div9(input logic [TOT_W-1:0] total);
      logic [PROD_W-1:0]          prod;
      logic [PROD_W-RECIP_SH-1:0] quot;
      prod = PROD_W'(total) * PROD_W'(RECIP9);
      quot = prod[PROD_W-1:RECIP_SH];
      if (quot > (PROD_W-RECIP_SH)'(CH_MAX)) begin
         return CH_W'(CH_MAX);
      end
      return quot[CH_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: src/box_blur_3x3_rgb.sv
// Pipeline: once the word that completes a window is accepted, its result passes
// through the steps store read, window sum and divide, then waits in an 8-word queue.
// Throughput: one word per clock, including drain words; input stalls only when
// the result queue plus the words in flight would fill it.
// Reset (synchronous, active high) clears counters, window, queue and loads the
// register defaults; the line store is not cleared.
// Top level of the 3x3 RGB box blur; uses bblur_pkg.
`default_nettype none

module box_blur_3x3_rgb #(
   parameter int unsigned MAX_WIDTH = bblur_pkg::MAX_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  bblur_pkg::req_word_type            req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output bblur_pkg::rsp_word_type            rsp_data,
   input  logic                               csr_wr_en,
   input  logic [bblur_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bblur_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bblur_pkg::*;

   localparam int unsigned AW     = $clog2(MAX_WIDTH);
   localparam int unsigned WW     = $clog2(MAX_WIDTH + 1);
   localparam int unsigned CMP_W  = (WW > FW_W) ? WW : FW_W;
   localparam int unsigned PTR_W  = $clog2(RSP_DEPTH);
   localparam int unsigned CNT_W  = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic [AW-1:0]     addr;
      logic [PIX_W-1:0]  px;
      logic              use_top;
      logic              use_mid;
      logic              emit;
      logic              first;
      logic              last1;
      logic              fend;
   } s1_type;

   // Configuration registers
   logic [FW_W-1:0]   fwidth_ff;
   logic [FH_W-1:0]   fheight_ff;
   logic              gray_ff;

   // Input position
   logic [AW-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;

   // Stage registers
   logic              s1_v_ff;
   s1_type            s1_ff, s1_in;
   logic              s1_fwd_ff;
   store_word_type    fwd_word_ff;
   store_word_type    rd_ff;
   logic              s2_v_ff, s2_first_ff, s2_last1_ff, s2_fend_ff;
   logic              s3_v_ff, s3_fend_ff;
   logic [TOT_W-1:0]  s3_tot_r_ff, s3_tot_g_ff, s3_tot_b_ff;
   col_sum_type       cs_ff [3];

   // Result queue
   rsp_word_type      q_mem [RSP_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  cnt_ff;

   // Line store
   store_word_type    store_mem [MAX_WIDTH];

   logic [WW-1:0]     w_eff, col_a, col_b, col_inc;
   logic [ROW_W-1:0]  h_eff, h_p1, row_b;
   logic              drain, drop, c_zero, go, push, pop;
   store_word_type    eff, wr_word;
   logic [PIX_W-1:0]  top, mid;
   col_sum_type       ncol;
   logic [TOT_W-1:0]  tot_r, tot_g, tot_b;
   rsp_word_type      rsp_word;
   logic [CNT_W:0]    load;

   function automatic logic [TOT_W-1:0] win_sum(input logic [COL_W-1:0] a,
                                                input logic [COL_W-1:0] b,
                                                input logic [COL_W-1:0] c,
                                                input logic first,
                                                input logic last1);
      logic [TOT_W-1:0] left, right;
      left  = first ? '0 : TOT_W'(a);
      right = last1 ? '0 : TOT_W'(c);
      return left + TOT_W'(b) + right;
   endfunction

   // Clip the frame size to the supported range
   always_comb begin
      if (fwidth_ff == '0) begin
         w_eff = WW'(1);
      end else if (CMP_W'(fwidth_ff) > CMP_W'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(fwidth_ff);
      end
      if (fheight_ff == '0) begin
         h_eff = ROW_W'(1);
      end else if (fheight_ff > FH_W'(MAX_HEIGHT)) begin
         h_eff = ROW_W'(MAX_HEIGHT);
      end else begin
         h_eff = ROW_W'(fheight_ff);
      end
      h_p1 = h_eff + ROW_W'(1);
   end

   // Place the incoming word in the frame and decide what it causes
   always_comb begin
      col_a = WW'(col_ff);
      row_b = row_ff;
      col_b = col_a;
      if (col_a >= w_eff) begin
         col_b = '0;
         row_b = row_ff + ROW_W'(1);
      end
      if (row_b > h_p1 || (row_b == h_p1 && col_b != '0)) begin
         row_b = '0;
         col_b = '0;
      end
      drain  = row_b >= h_eff;
      drop   = (req_data.opcode == OP_DRAIN) && !drain;
      c_zero = col_b == '0;

      s1_in.addr    = AW'(col_b);
      s1_in.px      = drain ? '0 : {req_data.red_in, req_data.green_in, req_data.blue_in};
      s1_in.use_top = row_b > ROW_W'(1);
      s1_in.use_mid = row_b != '0;
      s1_in.emit    = c_zero ? (row_b > ROW_W'(1)) : (row_b != '0);
      s1_in.first   = c_zero ? (w_eff == WW'(1)) : (col_b == WW'(1));
      s1_in.last1   = c_zero;
      s1_in.fend    = c_zero && (row_b == h_p1);

      // Advance the position; a finished frame restarts at the origin
      col_inc = col_b + WW'(1);
      col_in  = AW'(col_b);
      row_in  = row_b;
      if (!drop) begin
         if (s1_in.fend) begin
            col_in = '0;
            row_in = '0;
         end else if (col_inc >= w_eff) begin
            col_in = '0;
            row_in = row_b + ROW_W'(1);
         end else begin
            col_in = AW'(col_inc);
         end
      end
   end

   // Hold input while the queue could not take every word in flight
   always_comb begin
      load = (CNT_W+1)'(cnt_ff) + (CNT_W+1)'(s1_v_ff) + (CNT_W+1)'(s2_v_ff)
           + (CNT_W+1)'(s3_v_ff);
      req_stall = load >= (CNT_W+1)'(RSP_DEPTH);
   end
   assign go = req_valid && !req_stall;

   // Store entry with forwarding of the write still in flight, and the new column
   always_comb begin
      eff        = s1_fwd_ff ? fwd_word_ff : rd_ff;
      top        = s1_ff.use_top ? eff.older : '0;
      mid        = s1_ff.use_mid ? eff.newer : '0;
      wr_word.older = eff.newer;
      wr_word.newer = s1_ff.px;
      ncol.r = COL_W'(top[23:16]) + COL_W'(mid[23:16]) + COL_W'(s1_ff.px[23:16]);
      ncol.g = COL_W'(top[15:8])  + COL_W'(mid[15:8])  + COL_W'(s1_ff.px[15:8]);
      ncol.b = COL_W'(top[7:0])   + COL_W'(mid[7:0])   + COL_W'(s1_ff.px[7:0]);
   end

   // Window totals from the shifted column sums
   always_comb begin
      tot_r = win_sum(cs_ff[0].r, cs_ff[1].r, cs_ff[2].r, s2_first_ff, s2_last1_ff);
      tot_g = win_sum(cs_ff[0].g, cs_ff[1].g, cs_ff[2].g, s2_first_ff, s2_last1_ff);
      tot_b = win_sum(cs_ff[0].b, cs_ff[1].b, cs_ff[2].b, s2_first_ff, s2_last1_ff);
   end

   // Divide by nine and pick gray or color
   always_comb begin
      rsp_word.red_out   = div9(s3_tot_r_ff);
      rsp_word.green_out = gray_ff ? rsp_word.red_out : div9(s3_tot_g_ff);
      rsp_word.blue_out  = gray_ff ? rsp_word.red_out : div9(s3_tot_b_ff);
      rsp_word.frame_end = s3_fend_ff;
   end

   assign push      = s3_v_ff;
   assign rsp_valid = cnt_ff != '0;
   assign rsp_data  = q_mem[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         fwidth_ff  <= FRAME_WIDTH_RST;
         fheight_ff <= FRAME_HEIGHT_RST;
         gray_ff    <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  fwidth_ff  <= csr_wdata[FW_W-1:0];
            CSR_FRAME_HEIGHT: fheight_ff <= csr_wdata[FH_W-1:0];
            CSR_GRAY_MODE:    gray_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Line store: read at acceptance, written back in the following cycle
   always_ff @(posedge clock) begin
      if (go && !drop) begin
         rd_ff <= store_mem[s1_in.addr];
      end
      if (s1_v_ff) begin
         store_mem[s1_ff.addr] <= wr_word;
      end
   end

   // Stage one payload and forwarding capture
   always_ff @(posedge clock) begin
      if (go && !drop) begin
         s1_ff       <= s1_in;
         s1_fwd_ff   <= s1_v_ff && (s1_ff.addr == s1_in.addr);
         fwd_word_ff <= wr_word;
      end
   end

   // Position, stage valids and window columns
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            cs_ff[i] <= '0;
         end
      end else begin
         if (go) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         s1_v_ff <= go && !drop;
         s2_v_ff <= s1_v_ff && s1_ff.emit;
         s3_v_ff <= s2_v_ff;
         if (s1_v_ff) begin
            cs_ff[0] <= cs_ff[1];
            cs_ff[1] <= cs_ff[2];
            cs_ff[2] <= ncol;
         end
      end
   end

   // Stage two and three payload
   always_ff @(posedge clock) begin
      s2_first_ff <= s1_ff.first;
      s2_last1_ff <= s1_ff.last1;
      s2_fend_ff  <= s1_ff.fend;
      s3_tot_r_ff <= tot_r;
      s3_tot_g_ff <= tot_g;
      s3_tot_b_ff <= tot_b;
      s3_fend_ff  <= s2_fend_ff;
   end

   // Result queue
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= rsp_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         cnt_ff <= cnt_ff + CNT_W'(push) - CNT_W'(pop);
      end
   end

endmodule

`default_nettype wire
